[rtl/core/assert_macros.svh]
// Assertion macros for the packet parser RTL.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[rtl/core/eegpp_pkg.sv]
`timescale 1ns / 1ps

package eegpp_pkg;

	localparam logic [7:0] SYNC_BYTE       = 8'hAA;
	localparam logic [7:0] CODE_QUALITY    = 8'h02;
	localparam logic [7:0] CODE_ATTENTION  = 8'h04;
	localparam logic [7:0] CODE_MEDITATION = 8'h05;
	localparam logic [7:0] CODE_BANDS      = 8'h83;
	localparam logic [7:0] CODE_RAW        = 8'h80;

	localparam int NUM_BANDS = 8;
	localparam int BAND_W    = 24;

	// Last byte lane of a band, and last byte of a skipped raw record
	localparam logic [1:0] LAST_LANE = 2'd2;
	localparam logic [2:0] LAST_BAND = 3'd7;

	typedef logic [NUM_BANDS-1:0][BAND_W-1:0] band_set_t;

	// Frame phase, one-hot
	typedef enum logic [4:0] {
		PH_SYNC1   = 5'b00001,
		PH_SYNC2   = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_CHECK   = 5'b10000
	} phase_t;

	// Record decoder state, one-hot
	typedef enum logic [6:0] {
		RK_CODE       = 7'b0000001,
		RK_QUALITY    = 7'b0000010,
		RK_ATTENTION  = 7'b0000100,
		RK_MEDITATION = 7'b0001000,
		RK_BANDLEN    = 7'b0010000,
		RK_BANDS      = 7'b0100000,
		RK_SKIP       = 7'b1000000
	} rec_kind_t;

	// Framer to decoder control
	typedef struct packed {
		logic start;   // good length byte: open a new frame
		logic step;    // payload byte to decode
		logic commit;  // good checksum: keep the pending values
	} dec_ctrl_t;

endpackage

[rtl/core/eeg_headset_packet_parser_top.sv]
`timescale 1ns / 1ps
// An accepted byte waits in the input register and is decoded from there; a checksum
// byte that closes a good frame loads the result register that drives the output.
// Throughput: one byte per cycle. The input stalls only while a checksum byte waits
// in the input register and the previous result is still held by a stalled output.
// Reset (arst_n low, asynchronous): hunt for first sync, zero the decoder values only.
`include "assert_macros.svh"

module eeg_headset_packet_parser_top #(
	parameter int MAX_PAYLOAD = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  signal_quality,
	output logic [7:0]  attention,
	output logic [7:0]  meditation,
	output logic [23:0] band_delta,
	output logic [23:0] band_theta,
	output logic [23:0] band_low_alpha,
	output logic [23:0] band_high_alpha,
	output logic [23:0] band_low_beta,
	output logic [23:0] band_high_beta,
	output logic [23:0] band_low_gamma,
	output logic [23:0] band_mid_gamma
);
	import eegpp_pkg::*;

	localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

	logic       valid_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q;
	logic [7:0] frame_len_q;
	logic [7:0] taken_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] quality_q, attention_q, meditation_q;
	band_set_t  bands_q;

	logic       blocked;
	logic       proc;
	logic       len_ok;
	logic       sum_ok;
	logic       load_out;
	logic [7:0] taken_next;
	dec_ctrl_t  dec_ctrl;
	logic [7:0] pend_quality, pend_attention, pend_meditation;
	band_set_t  pend_bands;

	// A checksum byte cannot move on while the last result is still held
	assign blocked  = (phase_q == PH_CHECK) && out_valid_q && out_stall;
	assign proc     = valid_s1 && !blocked;
	assign in_stall = valid_s1 && blocked;

	assign len_ok     = (byte_s1 != 8'd0) && (byte_s1 <= MAX_LEN);
	assign sum_ok     = (byte_s1 == ~sum_q);
	assign taken_next = taken_q + 8'd1;
	assign load_out   = proc && (phase_q == PH_CHECK) && sum_ok;

	assign dec_ctrl.start  = proc && (phase_q == PH_LENGTH) && len_ok;
	assign dec_ctrl.step   = proc && (phase_q == PH_PAYLOAD);
	assign dec_ctrl.commit = load_out;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
	end

	// Frame tracking: sync, length, payload count and sum, checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SYNC1;
			frame_len_q <= '0;
			taken_q     <= '0;
			sum_q       <= '0;
		end else if (proc) begin
			unique case (phase_q)
				PH_SYNC2: phase_q <= (byte_s1 == SYNC_BYTE) ? PH_LENGTH : PH_SYNC1;
				PH_LENGTH: begin
					if (len_ok) begin
						frame_len_q <= byte_s1;
						taken_q     <= '0;
						sum_q       <= '0;
						phase_q     <= PH_PAYLOAD;
					end else begin
						phase_q <= PH_SYNC1;
					end
				end
				PH_PAYLOAD: begin
					sum_q   <= sum_q + byte_s1;
					taken_q <= taken_next;
					if (taken_next >= frame_len_q) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: phase_q <= PH_SYNC1;
				default:  phase_q <= (byte_s1 == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
			endcase
		end
	end

	eegpp_decoder u_decoder (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (dec_ctrl),
		.rx_byte         (byte_s1),
		.pend_quality    (pend_quality),
		.pend_attention  (pend_attention),
		.pend_meditation (pend_meditation),
		.pend_bands      (pend_bands)
	);

	// Result register: load on a good checksum, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			quality_q    <= pend_quality;
			attention_q  <= pend_attention;
			meditation_q <= pend_meditation;
			bands_q      <= pend_bands;
		end
	end

	assign out_valid       = out_valid_q;
	assign signal_quality  = quality_q;
	assign attention       = attention_q;
	assign meditation      = meditation_q;
	assign band_delta      = bands_q[0];
	assign band_theta      = bands_q[1];
	assign band_low_alpha  = bands_q[2];
	assign band_high_alpha = bands_q[3];
	assign band_low_beta   = bands_q[4];
	assign band_high_beta  = bands_q[5];
	assign band_low_gamma  = bands_q[6];
	assign band_mid_gamma  = bands_q[7];

	// Checks
	`ASSERT_NEVER(a_stall_only_on_check, clk, arst_n, in_stall && !(valid_s1 && (phase_q == PH_CHECK) && out_valid_q), "input stalled outside a held checksum byte")
	`ASSERT_CLK(a_count_in_frame, clk, arst_n, (phase_q == PH_PAYLOAD) |-> (taken_q < frame_len_q), "payload count ran past frame length")
	`ASSERT_CLK(a_result_from_check, clk, arst_n, (load_out) |=> (out_valid_q && (phase_q == PH_SYNC1)), "good checksum did not yield a result")
	`ASSERT_NEVER(a_start_commit_apart, clk, arst_n, dec_ctrl.start && (dec_ctrl.step || dec_ctrl.commit), "decoder control overlap")

endmodule

[rtl/core/eegpp_decoder.sv]
`timescale 1ns / 1ps

module eegpp_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  eegpp_pkg::dec_ctrl_t ctrl,
	input  logic [7:0]          rx_byte,
	output logic [7:0]          pend_quality,
	output logic [7:0]          pend_attention,
	output logic [7:0]          pend_meditation,
	output eegpp_pkg::band_set_t pend_bands
);
	import eegpp_pkg::*;

	rec_kind_t  kind_q;
	logic [2:0] band_idx_q;
	logic [1:0] lane_q;
	logic [7:0] quality_q, attention_q, meditation_q;
	logic [7:0] kept_quality_q, kept_attention_q, kept_meditation_q;
	band_set_t  bands_q;

	// Decode one payload byte per step; restore kept values at frame start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q            <= RK_CODE;
			band_idx_q        <= '0;
			lane_q            <= '0;
			quality_q         <= '0;
			attention_q       <= '0;
			meditation_q      <= '0;
			bands_q           <= '0;
			kept_quality_q    <= '0;
			kept_attention_q  <= '0;
			kept_meditation_q <= '0;
		end else begin
			if (ctrl.start) begin
				kind_q       <= RK_CODE;
				band_idx_q   <= '0;
				lane_q       <= '0;
				quality_q    <= kept_quality_q;
				attention_q  <= kept_attention_q;
				meditation_q <= kept_meditation_q;
				bands_q      <= '0;
			end else if (ctrl.step) begin
				unique case (kind_q)
					RK_QUALITY: begin
						quality_q <= rx_byte;
						kind_q    <= RK_CODE;
					end
					RK_ATTENTION: begin
						attention_q <= rx_byte;
						kind_q      <= RK_CODE;
					end
					RK_MEDITATION: begin
						meditation_q <= rx_byte;
						kind_q       <= RK_CODE;
					end
					RK_BANDLEN: begin
						// length byte is ignored
						kind_q     <= RK_BANDS;
						band_idx_q <= '0;
						lane_q     <= '0;
					end
					RK_BANDS: begin
						// big-endian: first byte is the top lane
						case (lane_q)
							2'd0:    bands_q[band_idx_q][23:16] <= rx_byte;
							2'd1:    bands_q[band_idx_q][15:8]  <= rx_byte;
							2'd2:    bands_q[band_idx_q][7:0]   <= rx_byte;
							default: ;
						endcase
						if (lane_q == LAST_LANE) begin
							lane_q <= '0;
							if (band_idx_q == LAST_BAND) begin
								kind_q     <= RK_CODE;
								band_idx_q <= '0;
							end else begin
								band_idx_q <= band_idx_q + 3'd1;
							end
						end else begin
							lane_q <= lane_q + 2'd1;
						end
					end
					RK_SKIP: begin
						if (lane_q == LAST_LANE) begin
							kind_q <= RK_CODE;
							lane_q <= '0;
						end else begin
							lane_q <= lane_q + 2'd1;
						end
					end
					default: begin
						// record code byte
						band_idx_q <= '0;
						lane_q     <= '0;
						case (rx_byte)
							CODE_QUALITY:    kind_q <= RK_QUALITY;
							CODE_ATTENTION:  kind_q <= RK_ATTENTION;
							CODE_MEDITATION: kind_q <= RK_MEDITATION;
							CODE_BANDS: begin
								bands_q <= '0;
								kind_q  <= RK_BANDLEN;
							end
							CODE_RAW:        kind_q <= RK_SKIP;
							default:         kind_q <= RK_CODE;
						endcase
					end
				endcase
			end

			// Keep the frame's quality, attention and meditation once its checksum is good
			if (ctrl.commit) begin
				kept_quality_q    <= quality_q;
				kept_attention_q  <= attention_q;
				kept_meditation_q <= meditation_q;
			end
		end
	end

	assign pend_quality    = quality_q;
	assign pend_attention  = attention_q;
	assign pend_meditation = meditation_q;
	assign pend_bands      = bands_q;

endmodule

[bench/tb_eeg_headset_packet_parser_top.sv]
`timescale 1ns / 1ps

module tb_eeg_headset_packet_parser_top;
	import eegpp_pkg::*;

	localparam int MAX_LEN        = 128;
	localparam int BAND_BYTES     = 24;
	localparam int RAW_SKIP_BYTES = 3;
	localparam int TARGET_BYTES   = 2000;
	localparam int MIN_FRAMES     = 60;
	localparam int IDLE_LIMIT     = 5000;
	localparam int TAIL_CYCLES    = 8;

	typedef struct {
		logic [7:0] b;
		int         gap;
		bit         drain;
	} tx_item_t;

	typedef struct packed {
		logic [7:0] quality;
		logic [7:0] attention;
		logic [7:0] meditation;
		band_set_t  bands;
	} eeg_frame_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  signal_quality;
	logic [7:0]  attention;
	logic [7:0]  meditation;
	logic [23:0] band_delta;
	logic [23:0] band_theta;
	logic [23:0] band_low_alpha;
	logic [23:0] band_high_alpha;
	logic [23:0] band_low_beta;
	logic [23:0] band_high_beta;
	logic [23:0] band_low_gamma;
	logic [23:0] band_mid_gamma;

	eeg_headset_packet_parser_top #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.signal_quality(signal_quality),
		.attention(attention),
		.meditation(meditation),
		.band_delta(band_delta),
		.band_theta(band_theta),
		.band_low_alpha(band_low_alpha),
		.band_high_alpha(band_high_alpha),
		.band_low_beta(band_low_beta),
		.band_high_beta(band_high_beta),
		.band_low_gamma(band_low_gamma),
		.band_mid_gamma(band_mid_gamma)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	tx_item_t   tx_items[$];
	eeg_frame_t frames_due[$];
	logic [7:0] body_q[$];
	int         mismatches = 0;
	int         sent_bytes = 0;
	int         good_frames = 0;
	logic       in_taken = 1'b0;
	int         idle_cycles = 0;

	string band_names[NUM_BANDS] = '{"band_delta", "band_theta", "band_low_alpha",
		"band_high_alpha", "band_low_beta", "band_high_beta", "band_low_gamma",
		"band_mid_gamma"};

	// Parser state mirrored in the bench
	phase_t     hunt_phase = PH_SYNC1;
	int         frame_len = 0;
	int         taken_cnt = 0;
	logic [7:0] sum8 = 8'h00;
	rec_kind_t  rec_state = RK_CODE;
	int         rec_pos = 0;
	logic [7:0] new_quality = 8'h00;
	logic [7:0] new_attention = 8'h00;
	logic [7:0] new_meditation = 8'h00;
	band_set_t  new_bands = '0;
	logic [7:0] held_quality = 8'h00;
	logic [7:0] held_attention = 8'h00;
	logic [7:0] held_meditation = 8'h00;

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Decode one payload byte into the pending record values
	task automatic decode_payload(input logic [7:0] b);
		logic [23:0] lane;
		case (rec_state)
			RK_QUALITY: begin
				new_quality = b;
				rec_state = RK_CODE;
			end
			RK_ATTENTION: begin
				new_attention = b;
				rec_state = RK_CODE;
			end
			RK_MEDITATION: begin
				new_meditation = b;
				rec_state = RK_CODE;
			end
			RK_BANDLEN: begin
				rec_state = RK_BANDS;
				rec_pos = 0;
			end
			RK_BANDS: begin
				lane = {16'h0000, b} << (16 - 8 * (rec_pos % 3));
				new_bands[rec_pos / 3] = new_bands[rec_pos / 3] | lane;
				rec_pos++;
				if (rec_pos >= BAND_BYTES) begin
					rec_state = RK_CODE;
					rec_pos = 0;
				end
			end
			RK_SKIP: begin
				rec_pos++;
				if (rec_pos >= RAW_SKIP_BYTES) begin
					rec_state = RK_CODE;
					rec_pos = 0;
				end
			end
			default: begin
				rec_pos = 0;
				if (b == CODE_QUALITY) begin
					rec_state = RK_QUALITY;
				end else if (b == CODE_ATTENTION) begin
					rec_state = RK_ATTENTION;
				end else if (b == CODE_MEDITATION) begin
					rec_state = RK_MEDITATION;
				end else if (b == CODE_BANDS) begin
					new_bands = '0;
					rec_state = RK_BANDLEN;
				end else if (b == CODE_RAW) begin
					rec_state = RK_SKIP;
				end else begin
					rec_state = RK_CODE;
				end
			end
		endcase
	endtask

	// Advance the framer by one accepted byte; queue the frame it closes
	task automatic predict_frame(input logic [7:0] b);
		eeg_frame_t fr;
		case (hunt_phase)
			PH_SYNC2: begin
				hunt_phase = (b == SYNC_BYTE) ? PH_LENGTH : PH_SYNC1;
			end
			PH_LENGTH: begin
				if (b == 8'h00 || int'(b) > MAX_LEN) begin
					hunt_phase = PH_SYNC1;
				end else begin
					frame_len = int'(b);
					taken_cnt = 0;
					sum8 = 8'h00;
					rec_state = RK_CODE;
					rec_pos = 0;
					new_quality = held_quality;
					new_attention = held_attention;
					new_meditation = held_meditation;
					new_bands = '0;
					hunt_phase = PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				sum8 = sum8 + b;
				decode_payload(b);
				taken_cnt++;
				if (taken_cnt >= frame_len)
					hunt_phase = PH_CHECK;
			end
			PH_CHECK: begin
				hunt_phase = PH_SYNC1;
				if (b == ~sum8) begin
					held_quality = new_quality;
					held_attention = new_attention;
					held_meditation = new_meditation;
					fr.quality = held_quality;
					fr.attention = held_attention;
					fr.meditation = held_meditation;
					fr.bands = new_bands;
					frames_due.push_back(fr);
				end
			end
			default: begin
				hunt_phase = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic queue_byte(input logic [7:0] b, input bit gapped, input bit drain);
		tx_item_t it;
		it.b = b;
		it.gap = gapped ? pick_gap() : 0;
		it.drain = drain;
		tx_items.push_back(it);
	endtask

	// Send sync, length and, for a good length, body (random padded) and checksum
	task automatic send_frame(input logic [7:0] len_byte, input bit sum_ok,
			input bit gapped, input bit drain);
		logic [7:0] s;
		logic [7:0] b;
		s = 8'h00;
		queue_byte(SYNC_BYTE, gapped, drain);
		queue_byte(SYNC_BYTE, gapped, 1'b0);
		queue_byte(len_byte, gapped, 1'b0);
		sent_bytes += 3;
		if (len_byte != 8'h00 && int'(len_byte) <= MAX_LEN) begin
			for (int i = 0; i < int'(len_byte); i++) begin
				b = (i < body_q.size()) ? body_q[i] : 8'($urandom);
				s = s + b;
				queue_byte(b, gapped, 1'b0);
			end
			if (sum_ok) begin
				queue_byte(~s, gapped, 1'b0);
				good_frames++;
			end else begin
				queue_byte(~s ^ 8'($urandom_range(1, 255)), gapped, 1'b0);
			end
			sent_bytes += int'(len_byte) + 1;
		end
		body_q.delete();
	endtask

	task automatic add_random_record();
		case ($urandom_range(0, 9))
			0, 1: begin
				body_q.push_back(CODE_QUALITY);
				body_q.push_back(8'($urandom));
			end
			2, 3: begin
				body_q.push_back(CODE_ATTENTION);
				body_q.push_back(8'($urandom));
			end
			4: begin
				body_q.push_back(CODE_MEDITATION);
				body_q.push_back(8'($urandom));
			end
			5: begin
				body_q.push_back(CODE_BANDS);
				body_q.push_back(8'($urandom));
				for (int i = 0; i < BAND_BYTES; i++)
					body_q.push_back(8'($urandom));
			end
			6: begin
				body_q.push_back(CODE_RAW);
				for (int i = 0; i < RAW_SKIP_BYTES; i++)
					body_q.push_back(8'($urandom));
			end
			default: begin
				body_q.push_back(8'($urandom));
			end
		endcase
	endtask

	// Drive input items and the output stall at the falling edge
	int gap_cnt = 0;
	int stall_left = 0;
	int run_left = 0;

	always @(negedge clk) begin : drive
		tx_item_t head;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (tx_items.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					head = tx_items[0];
					if (head.drain && frames_due.size() != 0) begin
						in_valid <= 1'b0;
					end else if (gap_cnt < head.gap) begin
						gap_cnt++;
						in_valid <= 1'b0;
					end else begin
						head = tx_items.pop_front();
						rx_byte <= head.b;
						in_valid <= 1'b1;
						gap_cnt = 0;
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (run_left > 0) begin
				run_left--;
				out_stall <= 1'b0;
			end else begin
				run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) :
					$urandom_range(0, 6);
				stall_left = pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// Check results against the oldest expectation, then predict from the input item
	always @(posedge clk) begin : watch
		eeg_frame_t want;
		band_set_t  seen;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && !in_stall;
			if (out_valid && !out_stall) begin
				if (frames_due.size() == 0) begin
					$error("unexpected result: quality %0h attention %0h meditation %0h",
						signal_quality, attention, meditation);
					mismatches++;
				end else begin
					want = frames_due.pop_front();
					seen = {band_mid_gamma, band_low_gamma, band_high_beta, band_low_beta,
						band_high_alpha, band_low_alpha, band_theta, band_delta};
					check_field("signal_quality", 24'(want.quality), 24'(signal_quality));
					check_field("attention", 24'(want.attention), 24'(attention));
					check_field("meditation", 24'(want.meditation), 24'(meditation));
					for (int i = 0; i < NUM_BANDS; i++)
						check_field(band_names[i], want.bands[i], seen[i]);
				end
			end
			if (in_valid && !in_stall)
				predict_frame(rx_byte);
		end
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** eeg_headset_packet_parser_top: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		int  r;
		int  len;
		bit  gapped;
		bit  drain;

		// Directed: value extremes
		body_q = '{CODE_QUALITY, 8'hFF, CODE_ATTENTION, 8'h00, CODE_MEDITATION, 8'h80};
		send_frame(8'd6, 1'b1, 1'b0, 1'b0);
		// Full band record with all-ones and all-zero bytes
		body_q = '{CODE_BANDS, 8'd24};
		for (int i = 0; i < BAND_BYTES; i++)
			body_q.push_back(i[0] ? 8'h00 : 8'hFF);
		send_frame(8'd26, 1'b1, 1'b0, 1'b0);
		// Wrong second sync byte, then a length byte that is itself a sync byte
		queue_byte(SYNC_BYTE, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0);
		send_frame(SYNC_BYTE, 1'b1, 1'b0, 1'b0);
		// Bad lengths: zero, just above the maximum, all ones
		send_frame(8'h00, 1'b1, 1'b0, 1'b0);
		send_frame(8'(MAX_LEN + 1), 1'b1, 1'b0, 1'b0);
		send_frame(8'hFF, 1'b1, 1'b1, 1'b0);
		// Longest frame
		while (body_q.size() < MAX_LEN)
			add_random_record();
		send_frame(8'(MAX_LEN), 1'b1, 1'b1, 1'b0);
		// Records cut off at the payload end
		body_q = '{CODE_QUALITY};
		send_frame(8'd1, 1'b1, 1'b0, 1'b0);
		body_q = '{CODE_BANDS, 8'h07, 8'h11, 8'h22, 8'h33, 8'h44};
		send_frame(8'd6, 1'b1, 1'b0, 1'b0);
		body_q = '{CODE_RAW, 8'h01};
		send_frame(8'd2, 1'b1, 1'b0, 1'b0);
		// Several band records: the last one wins
		body_q = '{CODE_BANDS, 8'h00};
		for (int i = 0; i < BAND_BYTES; i++)
			body_q.push_back(8'($urandom));
		body_q.push_back(CODE_BANDS);
		body_q.push_back(8'h00);
		body_q.push_back(8'h5A);
		send_frame(8'd29, 1'b1, 1'b0, 1'b0);
		// Bad checksum keeps old values; hold off until all results are in
		body_q = '{CODE_QUALITY, 8'h11, CODE_ATTENTION, 8'h22};
		send_frame(8'd4, 1'b0, 1'b0, 1'b1);
		body_q = '{8'h01, 8'h03, 8'h06, 8'hFE};
		send_frame(8'd4, 1'b1, 1'b0, 1'b1);
		// Raw record hides codes in its skipped bytes
		body_q = '{CODE_RAW, CODE_QUALITY, CODE_ATTENTION, CODE_MEDITATION,
			CODE_ATTENTION, 8'h33};
		send_frame(8'd6, 1'b1, 1'b0, 1'b0);

		// Random: mostly well-formed frames, some bad sums, bad lengths and noise
		while (sent_bytes < TARGET_BYTES || good_frames < MIN_FRAMES) begin
			r = $urandom_range(0, 99);
			gapped = ($urandom_range(0, 3) != 0);
			drain = ($urandom_range(0, 49) == 0);
			if (r < 90) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_LEN) :
					$urandom_range(1, 32);
				while (body_q.size() < len)
					add_random_record();
				send_frame(8'(len), r < 80, gapped, drain);
			end else if (r < 95) begin
				len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_LEN + 1, 255);
				send_frame(8'(len), 1'b1, gapped, drain);
			end else begin
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++)
					queue_byte(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom),
						gapped, 1'b0);
			end
		end

		// Hold reset, then release it away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Drain the stimulus and every expected result, then watch for strays
		while (tx_items.size() != 0)
			@(posedge clk);
		while (in_valid)
			@(posedge clk);
		while (frames_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("** eeg_headset_packet_parser_top: PASSED **");
		else
			$display("** eeg_headset_packet_parser_top: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/eegpp_pkg.sv
rtl/core/eegpp_decoder.sv
rtl/core/eeg_headset_packet_parser_top.sv
bench/tb_eeg_headset_packet_parser_top.sv
